// ===== rtl/double_ended_queue_checker_top_macros.svh =====
// Assertion helpers shared by the deque checker RTL.
`ifndef DOUBLE_ENDED_QUEUE_CHECKER_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque checker: assertion failed");

// Next-cycle implication, checked only out of reset.
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque checker: assertion failed");

`endif

// ===== rtl/dq_pkg.sv =====
package dq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int OCC_W    = 11;
  localparam int OP_W     = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_BACK   = 3'd0,
    OP_TAKE_BACK  = 3'd1,
    OP_ADD_FRONT  = 3'd2,
    OP_TAKE_FRONT = 3'd3,
    OP_NOP        = 3'd4
  } op_t;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Item in flight between access issue and result.
  typedef struct packed {
    logic                     vld;
    logic                     is_pop;
    logic                     empty;
    logic                     dropped;
    logic signed [WORD_W-1:0] expect_word;
    logic [OCC_W-1:0]         occ;
  } pend_t;

  function automatic addr_t ring_next(input addr_t i);
    return (i == addr_t'(CAPACITY - 1)) ? '0 : addr_t'(i + 1'b1);
  endfunction

  function automatic addr_t ring_prev(input addr_t i);
    return (i == '0) ? addr_t'(CAPACITY - 1) : addr_t'(i - 1'b1);
  endfunction

endpackage

// ===== rtl/dq_ram.sv =====
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/dq_ctrl.sv =====
`include "double_ended_queue_checker_top_macros.svh"

module dq_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [dq_pkg::OP_W-1:0]          op,
  input  logic signed [dq_pkg::WORD_W-1:0] value,
  output logic                             ram_we,
  output dq_pkg::addr_t                    ram_addr,
  output logic [dq_pkg::WORD_W-1:0]        ram_wdata,
  output dq_pkg::pend_t                    pend
);
  import dq_pkg::*;

  addr_t front_r, front_nxt;
  addr_t back_r, back_nxt;
  cnt_t  cnt_r, cnt_nxt;
  pend_t pend_r, pend_nxt;
  logic  full, empty;

  assign full  = (cnt_r == cnt_t'(CAPACITY));
  assign empty = (cnt_r == '0);

  always_comb begin
    front_nxt   = front_r;
    back_nxt    = back_r;
    cnt_nxt     = cnt_r;
    ram_we      = 1'b0;
    ram_addr    = front_r;
    ram_wdata   = value;
    pend_nxt    = '0;
    if (accept) begin
      pend_nxt.vld         = 1'b1;
      pend_nxt.expect_word = value;
      unique case (op)
        OP_ADD_BACK: begin
          if (full) begin
            pend_nxt.dropped = 1'b1;
          end else begin
            ram_we   = 1'b1;
            ram_addr = back_r;
            back_nxt = ring_next(back_r);
            cnt_nxt  = cnt_t'(cnt_r + 1'b1);
          end
        end
        OP_ADD_FRONT: begin
          if (full) begin
            pend_nxt.dropped = 1'b1;
          end else begin
            ram_we    = 1'b1;
            front_nxt = ring_prev(front_r);
            ram_addr  = front_nxt;
            cnt_nxt   = cnt_t'(cnt_r + 1'b1);
          end
        end
        OP_TAKE_BACK: begin
          pend_nxt.is_pop = 1'b1;
          if (empty) begin
            pend_nxt.empty = 1'b1;
          end else begin
            back_nxt = ring_prev(back_r);
            ram_addr = back_nxt;
            cnt_nxt  = cnt_t'(cnt_r - 1'b1);
          end
        end
        OP_TAKE_FRONT: begin
          pend_nxt.is_pop = 1'b1;
          if (empty) begin
            pend_nxt.empty = 1'b1;
          end else begin
            ram_addr  = front_r;
            front_nxt = ring_next(front_r);
            cnt_nxt   = cnt_t'(cnt_r - 1'b1);
          end
        end
        default: begin
          // no-op, including unused codes
        end
      endcase
      pend_nxt.occ = OCC_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r    <= '0;
      back_r     <= '0;
      cnt_r      <= '0;
      pend_r.vld <= 1'b0;
    end else begin
      front_r    <= front_nxt;
      back_r     <= back_nxt;
      cnt_r      <= cnt_nxt;
      pend_r.vld <= pend_nxt.vld;
    end
    pend_r.is_pop      <= pend_nxt.is_pop;
    pend_r.empty       <= pend_nxt.empty;
    pend_r.dropped     <= pend_nxt.dropped;
    pend_r.expect_word <= pend_nxt.expect_word;
    pend_r.occ         <= pend_nxt.occ;
  end

  assign pend = pend_r;

  `DQ_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= cnt_t'(CAPACITY))
  `DQ_ASSERT_NOW(a_drop_full, clk, rst_n, pend_r.vld && pend_r.dropped, full)
  `DQ_ASSERT_NOW(a_empty_pop, clk, rst_n, pend_r.vld && pend_r.empty, empty && pend_r.is_pop)
  `DQ_ASSERT_NEXT(a_idle_hold, clk, rst_n, !accept, $stable(cnt_r) && $stable(front_r))

endmodule

// ===== rtl/dq_resp.sv =====
`include "double_ended_queue_checker_top_macros.svh"

module dq_resp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dq_pkg::pend_t                     pend,
  input  logic [dq_pkg::WORD_W-1:0]         rd_word,
  output logic                              valid,
  output logic signed [dq_pkg::WORD_W-1:0]  popped_word,
  output logic                              was_empty,
  output logic                              push_dropped,
  output logic                              pop_matched,
  output logic                              all_matched,
  output logic [dq_pkg::OCC_W-1:0]          occupancy
);
  import dq_pkg::*;

  logic flag_r, flag_nxt;

  always_comb begin
    if (!pend.is_pop) begin
      popped_word = '0;
    end else if (pend.empty) begin
      popped_word = '1;   // all ones: -1
    end else begin
      popped_word = rd_word;
    end
    pop_matched = !pend.is_pop || (popped_word == pend.expect_word);
    flag_nxt    = (pend.vld) ? (flag_r && pop_matched) : flag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b1;
    end else begin
      flag_r <= flag_nxt;
    end
  end

  assign valid        = pend.vld;
  assign was_empty    = pend.empty;
  assign push_dropped = pend.dropped;
  assign all_matched  = flag_nxt;
  assign occupancy    = pend.occ;

  `DQ_ASSERT_NEXT(a_flag_sticky, clk, rst_n, !flag_r, !flag_r)
  `DQ_ASSERT_NOW(a_flag_fall, clk, rst_n, valid && flag_r && !all_matched,
                 pend.is_pop && !pop_matched)
  `DQ_ASSERT_NOW(a_empty_word, clk, rst_n, valid && was_empty, popped_word == '1)

endmodule

// ===== rtl/double_ended_queue_checker_top.sv =====
// Bounded double-ended queue checker.
// Input channel: an item is taken at a clock edge with start high and busy
// low. in_operation selects push back, pop back, push front, pop front or
// no-op (unused codes act as no-op); in_value is the word to push, or the
// word a pop is expected to return.
// Result channel: one result per item, shown for exactly one cycle with
// out_valid high, in the cycle after the item is taken. The receiver cannot
// stall, so results never back up.
// Throughput: one item per cycle; busy stays low. Each item makes at most
// one access to the single-port word memory (1024 x 32, registered read):
// a push writes at the accept edge, a pop reads at the accept edge and the
// word comes out of the memory register with the result. Indices and the
// held count update at the accept edge, so back-to-back items see them.
// A push right before a pop of the same slot is safe: the write lands at
// an earlier edge than the read.
// Reset (rst_n low, synchronous): queue empty, indices at zero, sticky
// all-matched flag set. Memory contents are not cleared; no pop can reach
// a slot that was never pushed.
module double_ended_queue_checker_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [dq_pkg::OP_W-1:0]          in_operation,
  input  logic signed [dq_pkg::WORD_W-1:0] in_value,
  output logic                             out_valid,
  output logic signed [dq_pkg::WORD_W-1:0] out_popped_word,
  output logic                             out_was_empty,
  output logic                             out_push_dropped,
  output logic                             out_pop_matched,
  output logic                             out_all_matched,
  output logic [dq_pkg::OCC_W-1:0]         out_occupancy
);
  import dq_pkg::*;

  logic              accept;
  logic              ram_we;
  addr_t             ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  pend_t             pend;

  // Every access finishes in its own cycle, so the input is never held off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Index and count bookkeeping, memory access issue.
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (in_operation),
    .value     (in_value),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .pend      (pend)
  );

  // Word store for the ring.
  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Compare against expected word, sticky match flag, result drive.
  dq_resp u_resp (
    .clk          (clk),
    .rst_n        (rst_n),
    .pend         (pend),
    .rd_word      (ram_rdata),
    .valid        (out_valid),
    .popped_word  (out_popped_word),
    .was_empty    (out_was_empty),
    .push_dropped (out_push_dropped),
    .pop_matched  (out_pop_matched),
    .all_matched  (out_all_matched),
    .occupancy    (out_occupancy)
  );

endmodule

// ===== verif/deque_result_checker.sv =====
// Watches both channels of the deque checker, predicts each result and
// compares it with what comes out.
module deque_result_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic [dq_pkg::OP_W-1:0]          in_operation,
  input  logic signed [dq_pkg::WORD_W-1:0] in_value,
  input  logic                             out_valid,
  input  logic signed [dq_pkg::WORD_W-1:0] out_popped_word,
  input  logic                             out_was_empty,
  input  logic                             out_push_dropped,
  input  logic                             out_pop_matched,
  input  logic                             out_all_matched,
  input  logic [dq_pkg::OCC_W-1:0]         out_occupancy,
  output int                               mismatch_count,
  output int                               results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import dq_pkg::*;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_word;
    logic                     was_empty;
    logic                     push_dropped;
    logic                     pop_matched;
    logic                     all_matched;
    logic [OCC_W-1:0]         occupancy;
  } deque_result_t;

  logic signed [WORD_W-1:0] shadow_store [CAPACITY];
  addr_t                    front_slot;
  addr_t                    back_slot;
  int                       held;
  logic                     all_ok;
  deque_result_t            pending_results [$];
  int                       result_no;

  function automatic addr_t wrap_slot(input int idx);
    return addr_t'((idx + CAPACITY) % CAPACITY);
  endfunction

  // Carries out one operation on the shadow deque and returns its result.
  task automatic apply_deque_op(input logic [OP_W-1:0] op,
                                input logic signed [WORD_W-1:0] val,
                                output deque_result_t res);
    res = '0;
    res.pop_matched = 1'b1;
    case (op)
      OP_ADD_BACK, OP_ADD_FRONT: begin
        if (held >= CAPACITY) begin
          res.push_dropped = 1'b1;
        end else begin
          if (op == OP_ADD_BACK) begin
            shadow_store[back_slot] = val;
            back_slot = wrap_slot(back_slot + 1);
          end else begin
            front_slot = wrap_slot(front_slot - 1);
            shadow_store[front_slot] = val;
          end
          held++;
        end
      end
      OP_TAKE_BACK, OP_TAKE_FRONT: begin
        if (held == 0) begin
          res.popped_word = -1;
          res.was_empty = 1'b1;
        end else begin
          if (op == OP_TAKE_BACK) begin
            back_slot = wrap_slot(back_slot - 1);
            res.popped_word = shadow_store[back_slot];
          end else begin
            res.popped_word = shadow_store[front_slot];
            front_slot = wrap_slot(front_slot + 1);
          end
          held--;
        end
        res.pop_matched = (res.popped_word == val);
        if (!res.pop_matched) all_ok = 1'b0;
      end
      default: ;
    endcase
    res.all_matched = all_ok;
    res.occupancy = OCC_W'(held);
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: result %0d: %s", $realtime, result_no, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s = %h, expected %h", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    deque_result_t want;
    deque_result_t got;
    if (!rst_n) begin
      front_slot = '0;
      back_slot = '0;
      held = 0;
      all_ok = 1'b1;
      result_no = 0;
      pending_results.delete();
    end else begin
      // predict first so that a result in the same cycle as its item would still line up
      if (start && !busy) begin
        apply_deque_op(in_operation, in_value, want);
        pending_results = {pending_results, want};
      end
      if (out_valid) begin
        got = '{out_popped_word, out_was_empty, out_push_dropped, out_pop_matched,
                out_all_matched, out_occupancy};
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          check_field("out_popped_word", got.popped_word, want.popped_word);
          check_field("out_was_empty", got.was_empty, want.was_empty);
          check_field("out_push_dropped", got.push_dropped, want.push_dropped);
          check_field("out_pop_matched", got.pop_matched, want.pop_matched);
          check_field("out_all_matched", got.all_matched, want.all_matched);
          check_field("out_occupancy", got.occupancy, want.occupancy);
        end
        result_no++;
      end
    end
    results_due = pending_results.size();
  end

endmodule

// ===== verif/tb_double_ended_queue_checker_top.sv =====
module tb_double_ended_queue_checker_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dq_pkg::*;

  // Random part length; with the directed items about 700 items in all.
  localparam int RANDOM_ITEMS   = 680;
  // Pops may carry a wrong expected word only from here on, so that the
  // sticky all-matched flag is seen high for a long stretch first.
  localparam int MISMATCH_FROM  = 450;
  // No sender gaps once this many random items have gone out.
  localparam int QUIET_TAIL     = 600;
  // Cycles without any accepted item or result before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 200;
  // Results come in the cycle after the item; margin cycles at the end.
  localparam int DRAIN_CYCLES   = 4;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [OP_W-1:0]          in_operation;
  logic signed [WORD_W-1:0] in_value;
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_popped_word;
  logic                     out_was_empty;
  logic                     out_push_dropped;
  logic                     out_pop_matched;
  logic                     out_all_matched;
  logic [OCC_W-1:0]         out_occupancy;
  int                       mismatch_count;
  int                       results_due;

  // Words the deque should hold, front at index 0. Only used to choose
  // pop values that match (or deliberately miss).
  logic signed [WORD_W-1:0] held_words [$];
  int                       issued;
  int                       idle_cycles;
  bit                       gaps_on;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  double_ended_queue_checker_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_popped_word  (out_popped_word),
    .out_was_empty    (out_was_empty),
    .out_push_dropped (out_push_dropped),
    .out_pop_matched  (out_pop_matched),
    .out_all_matched  (out_all_matched),
    .out_occupancy    (out_occupancy)
  );

  deque_result_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_popped_word  (out_popped_word),
    .out_was_empty    (out_was_empty),
    .out_push_dropped (out_push_dropped),
    .out_pop_matched  (out_pop_matched),
    .out_all_matched  (out_all_matched),
    .out_occupancy    (out_occupancy),
    .mismatch_count   (mismatch_count),
    .results_due      (results_due)
  );

  // Drives one item at the falling edge and holds it until a rising edge
  // sees busy low. start stays high into the next item when there is no gap.
  task automatic send(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] val);
    case (op)
      OP_ADD_BACK:   if (held_words.size() < CAPACITY) held_words = {held_words, val};
      OP_ADD_FRONT:  if (held_words.size() < CAPACITY) held_words = {val, held_words};
      OP_TAKE_BACK:  if (held_words.size() > 0) held_words.delete(held_words.size() - 1);
      OP_TAKE_FRONT: if (held_words.size() > 0) held_words.delete(0);
      default: ;
    endcase
    @(negedge clk);
    start <= 1'b1;
    in_operation <= op;
    in_value <= val;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Lowers start for the given number of cycles; the payload carries junk
  // meanwhile, which the block must ignore.
  task automatic pause(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    in_operation <= OP_W'($urandom);
    in_value <= $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic maybe_pause();
    if (gaps_on && issued < QUIET_TAIL && $urandom_range(0, 3) == 0)
      pause($urandom_range(1, 7));
  endtask

  // Push values lean on the sign and all-ones extremes.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -1;
      3:       return 0;
      default: return $urandom;
    endcase
  endfunction

  // Expected word for a pop from the given end; a dishonest pop has one
  // bit flipped so that it cannot match.
  function automatic logic signed [WORD_W-1:0] pop_value(input logic [OP_W-1:0] op,
                                                         input bit honest);
    logic signed [WORD_W-1:0] v;
    if (held_words.size() == 0) v = -1;
    else if (op == OP_TAKE_BACK) v = held_words[$];
    else v = held_words[0];
    if (!honest) v = v ^ (32'sd1 << $urandom_range(0, 31));
    return v;
  endfunction

  // One item of a well-formed sequence: pushes slightly outweigh pops so the
  // deque grows a little, pops mostly carry the right expected word.
  task automatic mixed_item();
    int              r;
    logic [OP_W-1:0] op;
    bit              honest;
    r = $urandom_range(0, 99);
    if (r < 25)      op = OP_ADD_BACK;
    else if (r < 47) op = OP_ADD_FRONT;
    else if (r < 67) op = OP_TAKE_BACK;
    else if (r < 87) op = OP_TAKE_FRONT;
    else if (r < 93) op = OP_NOP;
    else             op = OP_W'($urandom_range(5, 7));
    honest = !(issued >= MISMATCH_FROM && $urandom_range(0, 19) == 0);
    if (op == OP_TAKE_BACK || op == OP_TAKE_FRONT) send(op, pop_value(op, honest));
    else send(op, pick_word());
  endtask

  initial begin
    int burst;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_NOP;
    in_value = '0;
    issued = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty pops that expect -1, field extremes at both ends,
    // no-op and the unused codes, pops from both ends back to empty, and
    // a push followed at once by a pop of the same slot.
    send(OP_TAKE_FRONT, -1);
    send(OP_TAKE_BACK, -1);
    send(OP_ADD_BACK, 32'sh7fff_ffff);
    send(OP_ADD_FRONT, 32'sh8000_0000);
    send(OP_ADD_BACK, 0);
    send(OP_ADD_FRONT, -1);
    send(OP_NOP, 32'sh5a5a_5a5a);
    send(OP_W'(5), 32'sha5a5_a5a5);
    send(OP_W'(6), -1);
    send(OP_W'(7), 32'sh8000_0000);
    send(OP_TAKE_BACK, 0);
    send(OP_TAKE_FRONT, -1);
    send(OP_TAKE_FRONT, 32'sh8000_0000);
    send(OP_TAKE_BACK, 32'sh7fff_ffff);
    send(OP_TAKE_BACK, -1);
    send(OP_ADD_BACK, 32'sh1234_5678);
    send(OP_TAKE_BACK, 32'sh1234_5678);
    send(OP_ADD_FRONT, 32'sh0bad_cafe);
    send(OP_TAKE_FRONT, 32'sh0bad_cafe);
    send(OP_ADD_FRONT, 32'sh7654_3210);
    send(OP_TAKE_BACK, 32'sh7654_3210);

    // Hold off until every outstanding result has come back.
    pause(1);
    while (results_due != 0) @(negedge clk);

    // Random: short well-formed bursts, and late in the run noise bursts
    // with any code and any value.
    while (issued < RANDOM_ITEMS) begin
      gaps_on = $urandom_range(0, 2) != 0;
      if (issued >= MISMATCH_FROM && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(4, 12);
        repeat (burst) begin
          maybe_pause();
          send(OP_W'($urandom), $urandom);
          issued++;
        end
      end else begin
        burst = $urandom_range(8, 40);
        repeat (burst) begin
          maybe_pause();
          mixed_item();
          issued++;
        end
      end
    end

    // Let everything come back, then DRAIN_CYCLES more for anything stray.
    @(negedge clk);
    start <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("double_ended_queue_checker_top verification clean");
    else
      $display("double_ended_queue_checker_top verification failed");
    $finish;
  end

  // Watchdog: any accepted item or result restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("double_ended_queue_checker_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
